/* design/assert_macros.svh */
// Assertion helpers shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

/* design/hmk3_pkg.sv */
package hmk3_pkg;

   localparam int MaxBitsDefault = 21;
   localparam int CoordWidth     = 21;
   localparam int KeyWidth       = 63;
   localparam int CfgWidth       = 5;
   localparam int RotWidth       = 6;

   localparam logic [1:0] ADDR_BITS_USED = 2'd0;

   // Combined table entry: {next rotation[8:3], digit[2:0]}
   typedef logic [RotWidth+2:0] rom_entry_type;

   localparam logic [5:0] NEXT_ROT [0:383] = '{
      6'd36,6'd28,6'd25,6'd27,6'd10,6'd10,6'd25,6'd27,
      6'd29,6'd11,6'd24,6'd24,6'd37,6'd11,6'd26,6'd26,
      6'd8,6'd8,6'd25,6'd27,6'd30,6'd38,6'd25,6'd27,
      6'd9,6'd39,6'd24,6'd24,6'd9,6'd31,6'd26,6'd26,
      6'd40,6'd24,6'd44,6'd32,6'd40,6'd6,6'd44,6'd6,
      6'd25,6'd7,6'd33,6'd7,6'd41,6'd41,6'd45,6'd45,
      6'd4,6'd42,6'd4,6'd46,6'd26,6'd42,6'd34,6'd46,
      6'd43,6'd43,6'd47,6'd47,6'd5,6'd27,6'd5,6'd35,
      6'd33,6'd35,6'd36,6'd28,6'd33,6'd35,6'd2,6'd2,
      6'd32,6'd32,6'd29,6'd3,6'd34,6'd34,6'd37,6'd3,
      6'd33,6'd35,6'd0,6'd0,6'd33,6'd35,6'd30,6'd38,
      6'd32,6'd32,6'd1,6'd39,6'd34,6'd34,6'd1,6'd31,
      6'd24,6'd42,6'd32,6'd46,6'd14,6'd42,6'd14,6'd46,
      6'd43,6'd43,6'd47,6'd47,6'd25,6'd15,6'd33,6'd15,
      6'd40,6'd12,6'd44,6'd12,6'd40,6'd26,6'd44,6'd34,
      6'd13,6'd27,6'd13,6'd35,6'd41,6'd41,6'd45,6'd45,
      6'd28,6'd41,6'd28,6'd22,6'd38,6'd43,6'd38,6'd22,
      6'd42,6'd40,6'd23,6'd23,6'd29,6'd39,6'd29,6'd39,
      6'd41,6'd36,6'd20,6'd36,6'd43,6'd30,6'd20,6'd30,
      6'd37,6'd31,6'd37,6'd31,6'd42,6'd40,6'd21,6'd21,
      6'd28,6'd18,6'd28,6'd45,6'd38,6'd18,6'd38,6'd47,
      6'd19,6'd19,6'd46,6'd44,6'd29,6'd39,6'd29,6'd39,
      6'd16,6'd36,6'd45,6'd36,6'd16,6'd30,6'd47,6'd30,
      6'd37,6'd31,6'd37,6'd31,6'd17,6'd17,6'd46,6'd44,
      6'd12,6'd4,6'd1,6'd3,6'd34,6'd34,6'd1,6'd3,
      6'd5,6'd35,6'd0,6'd0,6'd13,6'd35,6'd2,6'd2,
      6'd32,6'd32,6'd1,6'd3,6'd6,6'd14,6'd1,6'd3,
      6'd33,6'd15,6'd0,6'd0,6'd33,6'd7,6'd2,6'd2,
      6'd16,6'd0,6'd20,6'd8,6'd16,6'd30,6'd20,6'd30,
      6'd1,6'd31,6'd9,6'd31,6'd17,6'd17,6'd21,6'd21,
      6'd28,6'd18,6'd28,6'd22,6'd2,6'd18,6'd10,6'd22,
      6'd19,6'd19,6'd23,6'd23,6'd29,6'd3,6'd29,6'd11,
      6'd9,6'd11,6'd12,6'd4,6'd9,6'd11,6'd26,6'd26,
      6'd8,6'd8,6'd5,6'd27,6'd10,6'd10,6'd13,6'd27,
      6'd9,6'd11,6'd24,6'd24,6'd9,6'd11,6'd6,6'd14,
      6'd8,6'd8,6'd25,6'd15,6'd10,6'd10,6'd25,6'd7,
      6'd0,6'd18,6'd8,6'd22,6'd38,6'd18,6'd38,6'd22,
      6'd19,6'd19,6'd23,6'd23,6'd1,6'd39,6'd9,6'd39,
      6'd16,6'd36,6'd20,6'd36,6'd16,6'd2,6'd20,6'd10,
      6'd37,6'd3,6'd37,6'd11,6'd17,6'd17,6'd21,6'd21,
      6'd4,6'd17,6'd4,6'd46,6'd14,6'd19,6'd14,6'd46,
      6'd18,6'd16,6'd47,6'd47,6'd5,6'd15,6'd5,6'd15,
      6'd17,6'd12,6'd44,6'd12,6'd19,6'd6,6'd44,6'd6,
      6'd13,6'd7,6'd13,6'd7,6'd18,6'd16,6'd45,6'd45,
      6'd4,6'd42,6'd4,6'd21,6'd14,6'd42,6'd14,6'd23,
      6'd43,6'd43,6'd22,6'd20,6'd5,6'd15,6'd5,6'd15,
      6'd40,6'd12,6'd21,6'd12,6'd40,6'd6,6'd23,6'd6,
      6'd13,6'd7,6'd13,6'd7,6'd41,6'd41,6'd22,6'd20
   };

   localparam logic [2:0] DIGIT [0:383] = '{
      3'd0,3'd7,3'd1,3'd6,3'd3,3'd4,3'd2,3'd5, 3'd7,3'd4,3'd6,3'd5,3'd0,3'd3,3'd1,3'd2,
      3'd4,3'd3,3'd5,3'd2,3'd7,3'd0,3'd6,3'd1, 3'd3,3'd0,3'd2,3'd1,3'd4,3'd7,3'd5,3'd6,
      3'd1,3'd0,3'd6,3'd7,3'd2,3'd3,3'd5,3'd4, 3'd0,3'd3,3'd7,3'd4,3'd1,3'd2,3'd6,3'd5,
      3'd3,3'd2,3'd4,3'd5,3'd0,3'd1,3'd7,3'd6, 3'd2,3'd1,3'd5,3'd6,3'd3,3'd0,3'd4,3'd7,
      3'd6,3'd1,3'd7,3'd0,3'd5,3'd2,3'd4,3'd3, 3'd1,3'd2,3'd0,3'd3,3'd6,3'd5,3'd7,3'd4,
      3'd2,3'd5,3'd3,3'd4,3'd1,3'd6,3'd0,3'd7, 3'd5,3'd6,3'd4,3'd7,3'd2,3'd1,3'd3,3'd0,
      3'd7,3'd6,3'd0,3'd1,3'd4,3'd5,3'd3,3'd2, 3'd6,3'd5,3'd1,3'd2,3'd7,3'd4,3'd0,3'd3,
      3'd5,3'd4,3'd2,3'd3,3'd6,3'd7,3'd1,3'd0, 3'd4,3'd7,3'd3,3'd0,3'd5,3'd6,3'd2,3'd1,
      3'd6,3'd7,3'd5,3'd4,3'd1,3'd0,3'd2,3'd3, 3'd7,3'd0,3'd4,3'd3,3'd6,3'd1,3'd5,3'd2,
      3'd0,3'd1,3'd3,3'd2,3'd7,3'd6,3'd4,3'd5, 3'd1,3'd6,3'd2,3'd5,3'd0,3'd7,3'd3,3'd4,
      3'd2,3'd3,3'd1,3'd0,3'd5,3'd4,3'd6,3'd7, 3'd3,3'd4,3'd0,3'd7,3'd2,3'd5,3'd1,3'd6,
      3'd4,3'd5,3'd7,3'd6,3'd3,3'd2,3'd0,3'd1, 3'd5,3'd2,3'd6,3'd1,3'd4,3'd3,3'd7,3'd0,
      3'd7,3'd0,3'd6,3'd1,3'd4,3'd3,3'd5,3'd2, 3'd0,3'd3,3'd1,3'd2,3'd7,3'd4,3'd6,3'd5,
      3'd3,3'd4,3'd2,3'd5,3'd0,3'd7,3'd1,3'd6, 3'd4,3'd7,3'd5,3'd6,3'd3,3'd0,3'd2,3'd1,
      3'd6,3'd7,3'd1,3'd0,3'd5,3'd4,3'd2,3'd3, 3'd7,3'd4,3'd0,3'd3,3'd6,3'd5,3'd1,3'd2,
      3'd4,3'd5,3'd3,3'd2,3'd7,3'd6,3'd0,3'd1, 3'd5,3'd6,3'd2,3'd1,3'd4,3'd7,3'd3,3'd0,
      3'd1,3'd6,3'd0,3'd7,3'd2,3'd5,3'd3,3'd4, 3'd6,3'd5,3'd7,3'd4,3'd1,3'd2,3'd0,3'd3,
      3'd5,3'd2,3'd4,3'd3,3'd6,3'd1,3'd7,3'd0, 3'd2,3'd1,3'd3,3'd0,3'd5,3'd6,3'd4,3'd7,
      3'd0,3'd1,3'd7,3'd6,3'd3,3'd2,3'd4,3'd5, 3'd1,3'd2,3'd6,3'd5,3'd0,3'd3,3'd7,3'd4,
      3'd2,3'd3,3'd5,3'd4,3'd1,3'd0,3'd6,3'd7, 3'd3,3'd0,3'd4,3'd7,3'd2,3'd1,3'd5,3'd6,
      3'd1,3'd0,3'd2,3'd3,3'd6,3'd7,3'd5,3'd4, 3'd0,3'd7,3'd3,3'd4,3'd1,3'd6,3'd2,3'd5,
      3'd7,3'd6,3'd4,3'd5,3'd0,3'd1,3'd3,3'd2, 3'd6,3'd1,3'd5,3'd2,3'd7,3'd0,3'd4,3'd3,
      3'd5,3'd4,3'd6,3'd7,3'd2,3'd3,3'd1,3'd0, 3'd4,3'd3,3'd7,3'd0,3'd5,3'd2,3'd6,3'd1,
      3'd3,3'd2,3'd0,3'd1,3'd4,3'd5,3'd7,3'd6, 3'd2,3'd5,3'd1,3'd6,3'd3,3'd4,3'd0,3'd7
   };

   function automatic rom_entry_type rom_lookup(input logic [RotWidth-1:0] rot,
                                                input logic [2:0] oct);
      logic [8:0] idx;
      idx = {rot, oct};
      return {NEXT_ROT[idx], DIGIT[idx]};
   endfunction

endpackage

/* design/hilbert_and_morton_key_3d_core.sv */
// 3D Hilbert and Morton key unit.
// Input channel: drive req_coord_x/y/z with start high; the item is taken at
// the edge where start is high and busy is low. busy is always low, so one
// item may enter every cycle.
// Result channel: rsp_hilbert_code and rsp_morton_code are shown for one
// cycle with done high; the receiver must take them then.
// Pipeline: one input stage, one stage per curve level through the rotation
// table and one output register lie between the accepting edge and done.
// The per-level table lookup chain sets the depth; throughput is one item
// per cycle.
// Configuration: APB register bits_used at address 0 (pwdata[4:0] kept; values
// above MaxBits saturate); write only while no items are in flight.
// Reset: bits_used returns to 21 and all in-flight items are dropped.
module hilbert_and_morton_key_3d_core #(
   parameter int MaxBits = hmk3_pkg::MaxBitsDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [hmk3_pkg::CoordWidth-1:0] req_coord_x,
   input  logic [hmk3_pkg::CoordWidth-1:0] req_coord_y,
   input  logic [hmk3_pkg::CoordWidth-1:0] req_coord_z,
   output logic                          done,
   output logic [hmk3_pkg::KeyWidth-1:0] rsp_hilbert_code,
   output logic [hmk3_pkg::KeyWidth-1:0] rsp_morton_code,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [1:0]                    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import hmk3_pkg::*;

   localparam int KW = 3*MaxBits;

   logic [CfgWidth-1:0] bits_used_ff;
   logic [CfgWidth-1:0] levels;

   assign csr_pready = 1'b1;
   assign busy       = 1'b0;
   assign csr_prdata = (csr_paddr == ADDR_BITS_USED)
                     ? {{(32-CfgWidth){1'b0}}, bits_used_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_used_ff <= CfgWidth'(21);
      end else if (csr_psel && csr_penable && csr_pwrite
                   && csr_paddr == ADDR_BITS_USED) begin
         bits_used_ff <= csr_pwdata[CfgWidth-1:0];
      end
   end

   assign levels = (bits_used_ff > CfgWidth'(MaxBits)) ? CfgWidth'(MaxBits) : bits_used_ff;

   // input stage: mask coords, build Morton key
   logic               s0_valid_ff;
   logic [MaxBits-1:0] s0_x_ff, s0_y_ff, s0_z_ff;
   logic [KW-1:0]      s0_morton_ff, morton_in;
   logic [MaxBits-1:0] s0_act_ff, act_in;

   always_comb begin
      morton_in = '0;
      for (int i = 0; i < MaxBits; i++) begin
         act_in[i] = (i < int'(levels));
         morton_in[3*i+2] = req_coord_z[i] & act_in[i];
         morton_in[3*i+1] = req_coord_y[i] & act_in[i];
         morton_in[3*i]   = req_coord_x[i] & act_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= start && !busy;
      end
      s0_x_ff      <= req_coord_x[MaxBits-1:0];
      s0_y_ff      <= req_coord_y[MaxBits-1:0];
      s0_z_ff      <= req_coord_z[MaxBits-1:0];
      s0_morton_ff <= morton_in;
      s0_act_ff    <= act_in;
   end

   // level stages, top bit first; coords and Morton key ride along
   logic               v   [0:MaxBits];
   logic [RotWidth-1:0] r  [0:MaxBits];
   logic [KW-1:0]      k   [0:MaxBits];
   logic [MaxBits-1:0] px  [0:MaxBits];
   logic [MaxBits-1:0] py  [0:MaxBits];
   logic [MaxBits-1:0] pz  [0:MaxBits];
   logic [MaxBits-1:0] pa  [0:MaxBits];
   logic [KW-1:0]      pm  [0:MaxBits];

   assign v[0]  = s0_valid_ff;
   assign r[0]  = '0;
   assign k[0]  = '0;
   assign px[0] = s0_x_ff;
   assign py[0] = s0_y_ff;
   assign pz[0] = s0_z_ff;
   assign pa[0] = s0_act_ff;
   assign pm[0] = s0_morton_ff;

   for (genvar g = 0; g < MaxBits; g++) begin : g_level
      localparam int B = MaxBits - 1 - g;
      hmk3_level #(.MaxBits(MaxBits)) u_level (
         .clock     (clock),
         .reset     (reset),
         .valid_in  (v[g]),
         .active_in (pa[g][B]),
         .oct_in    ({px[g][B], py[g][B], pz[g][B]}),
         .rot_in    (r[g]),
         .key_in    (k[g]),
         .valid_out (v[g+1]),
         .rot_out   (r[g+1]),
         .key_out   (k[g+1])
      );
      always_ff @(posedge clock) begin
         px[g+1] <= px[g];
         py[g+1] <= py[g];
         pz[g+1] <= pz[g];
         pa[g+1] <= pa[g];
         pm[g+1] <= pm[g];
      end
   end

   logic          done_ff;
   logic [KW-1:0] hil_ff, mor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= v[MaxBits];
      end
      hil_ff <= k[MaxBits];
      mor_ff <= pm[MaxBits];
   end

   assign done             = done_ff;
   assign rsp_hilbert_code = KeyWidth'(hil_ff);
   assign rsp_morton_code  = KeyWidth'(mor_ff);
endmodule

/* design/hmk3_level.sv */
// One curve level: rotation and octant in, digit appended, rotation stepped.
module hmk3_level #(
   parameter int MaxBits = hmk3_pkg::MaxBitsDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        valid_in,
   input  logic                        active_in,
   input  logic [2:0]                  oct_in,
   input  logic [hmk3_pkg::RotWidth-1:0] rot_in,
   input  logic [3*MaxBits-1:0]        key_in,
   output logic                        valid_out,
   output logic [hmk3_pkg::RotWidth-1:0] rot_out,
   output logic [3*MaxBits-1:0]        key_out
);
   import hmk3_pkg::*;

   rom_entry_type entry;
   logic                valid_ff;
   logic [RotWidth-1:0] rot_ff, rot_in_w;
   logic [3*MaxBits-1:0] key_ff, key_in_w;

   assign entry = rom_lookup(rot_in, oct_in);

   always_comb begin
      rot_in_w = rot_in;
      key_in_w = key_in;
      // skip levels above the configured count
      if (active_in) begin
         rot_in_w = entry[8:3];
         key_in_w = (key_in << 3) | (3*MaxBits)'(entry[2:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rot_ff <= rot_in_w;
      key_ff <= key_in_w;
   end

   assign valid_out = valid_ff;
   assign rot_out   = rot_ff;
   assign key_out   = key_ff;
endmodule

/* design/hmk3_checker.sv */
module hmk3_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          busy,
   input logic                          done,
   input logic [hmk3_pkg::KeyWidth-1:0] rsp_hilbert_code,
   input logic [hmk3_pkg::KeyWidth-1:0] rsp_morton_code,
   input logic                          csr_pready
);
   import hmk3_pkg::*;
`include "assert_macros.svh"
   `ASSERT_IMPLY(a_busy_low, clock, reset, 1'b1, !busy, "busy asserted")
   `ASSERT_IMPLY(a_pready, clock, reset, 1'b1, csr_pready, "pready low")
   `ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !done, "done right after reset")
   // all-zero coordinates walk octant zero only, which always gives digit zero
   `ASSERT_IMPLY(a_zero_keys, clock, reset, done && rsp_morton_code == '0, rsp_hilbert_code == '0, "key mismatch")
endmodule

bind hilbert_and_morton_key_3d_core hmk3_checker u_hmk3_checker (
   .clock            (clock),
   .reset            (reset),
   .busy             (busy),
   .done             (done),
   .rsp_hilbert_code (rsp_hilbert_code),
   .rsp_morton_code  (rsp_morton_code),
   .csr_pready       (csr_pready)
);

/* tb/hilbert_and_morton_key_3d_core_test.sv */
class key_scoreboard;
   logic [62:0] hilbert_q[$];
   logic [62:0] morton_q[$];
   int unsigned n_mismatch;
   logic [4:0]  levels_cfg;

   function new();
      n_mismatch = 0;
      levels_cfg = 5'd21;
   endfunction

   // Walk the levels top down, stepping the rotation state per octant.
   function void note_item(logic [20:0] cx, logic [20:0] cy, logic [20:0] cz);
      int unsigned lv;
      logic [62:0] hk, mk;
      logic [5:0]  rot;
      logic [2:0]  oct;
      logic [8:0]  idx;
      lv = (levels_cfg > 5'd21) ? 21 : levels_cfg;
      hk = '0;
      mk = '0;
      rot = '0;
      for (int k = lv; k > 0; k--) begin
         oct = {cx[k-1], cy[k-1], cz[k-1]};
         idx = {rot, oct};
         hk = {hk[59:0], hmk3_pkg::DIGIT[idx]};
         rot = hmk3_pkg::NEXT_ROT[idx];
         mk = {mk[59:0], cz[k-1], cy[k-1], cx[k-1]};
      end
      hilbert_q.push_back(hk);
      morton_q.push_back(mk);
   endfunction

   function void check_key(logic [62:0] hk, logic [62:0] mk);
      logic [62:0] eh, em;
      if (hilbert_q.size() == 0) begin
         n_mismatch++;
         if (n_mismatch <= 10) $display("unexpected key h=%h m=%h", hk, mk);
         return;
      end
      eh = hilbert_q.pop_front();
      em = morton_q.pop_front();
      if (eh !== hk || em !== mk) begin
         n_mismatch++;
         if (n_mismatch <= 10)
            $display("key mismatch: hilbert exp %h got %h, morton exp %h got %h",
                     eh, hk, em, mk);
      end
   endfunction
endclass

module hilbert_and_morton_key_3d_core_test;
   import hmk3_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [20:0] req_coord_x = '0, req_coord_y = '0, req_coord_z = '0;
   logic        done;
   logic [62:0] rsp_hilbert_code, rsp_morton_code;
   logic        csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [1:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   key_scoreboard sb = new();

   hilbert_and_morton_key_3d_core u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock)
      if (!reset && done) sb.check_key(rsp_hilbert_code, rsp_morton_code);

   task automatic write_bits_used(logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_BITS_USED;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.levels_cfg = value[4:0];
   endtask

   // Hold start until busy is low at an edge, then note the item.
   task automatic send_coords(logic [20:0] cx, logic [20:0] cy, logic [20:0] cz,
                              bit keep_start);
      start       <= 1'b1;
      req_coord_x <= cx;
      req_coord_y <= cy;
      req_coord_z <= cz;
      do @(posedge clock); while (busy);
      sb.note_item(cx, cy, cz);
      // drop start for one cycle so the next item starts on a fresh edge
      if (!keep_start) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic drain();
      while (sb.hilbert_q.size() != 0) @(posedge clock);
      repeat (MaxBitsDefault + 6) @(posedge clock);
   endtask

   task automatic random_burst_run(int unsigned n_items, bit deep_bits);
      int unsigned left, burst;
      logic [20:0] cx, cy, cz;
      left = n_items;
      while (left > 0) begin
         burst = $urandom_range(1, 24);
         if (($urandom & 3) == 0) burst = 40;
         if (burst > left) burst = left;
         for (int i = 0; i < burst; i++) begin
            cx = 21'($urandom);
            cy = 21'($urandom);
            cz = 21'($urandom);
            if (deep_bits && ($urandom & 7) == 0) cx = '1;
            send_coords(cx, cy, cz, i != burst - 1);
         end
         left -= burst;
         if (($urandom & 1) == 0) repeat ($urandom_range(1, 30)) @(posedge clock);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset count, extremes, every octant at the top level.
      send_coords('0, '0, '0, 1'b0);
      send_coords('1, '1, '1, 1'b0);
      send_coords(21'h155555, 21'h0AAAAA, 21'h1FFFFF, 1'b1);
      for (int o = 0; o < 8; o++)
         send_coords({o[2], 20'h0}, {o[1], 20'h0}, {o[0], 20'h0}, o != 7);
      drain();

      // Bits above the count must be ignored; zero count gives zero keys.
      write_bits_used(32'd1);
      send_coords('1, 21'h1FFFFE, '1, 1'b1);
      send_coords(21'h000001, 21'h0, 21'h1, 1'b0);
      drain();
      write_bits_used(32'd0);
      send_coords('1, '1, '1, 1'b0);
      drain();
      // Above the maximum saturates.
      write_bits_used(32'd31);
      send_coords('1, 21'h12345, '1, 1'b1);
      send_coords(21'h1ABCDE, 21'h054321, 21'h0F0F0F, 1'b0);
      drain();

      write_bits_used(32'd21);
      random_burst_run(400, 1'b1);
      // Pause until every key has come back.
      drain();
      write_bits_used(32'd1);
      random_burst_run(120, 1'b0);
      drain();
      write_bits_used($urandom_range(2, 20));
      random_burst_run(250, 1'b0);
      drain();
      write_bits_used(32'd0);
      random_burst_run(40, 1'b0);
      drain();
      write_bits_used($urandom_range(22, 31));
      random_burst_run(150, 1'b0);
      drain();
      write_bits_used(32'd21);
      random_burst_run(150, 1'b1);
      drain();

      if (sb.n_mismatch == 0 && sb.hilbert_q.size() == 0)
         $display("hilbert_and_morton_key_3d_core test passed");
      else
         $display("hilbert_and_morton_key_3d_core test failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("hilbert_and_morton_key_3d_core test failed");
      $finish;
   end
endmodule
